// ===== rtl/core/ptt_pkg.sv =====
// Package for the periodic timer table: sizes, request and status codes, FSM states.
package ptt_pkg;
  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int TIME_W = 64;
  localparam int CNT_W = 32;

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_STOP = 3'd1;
  localparam logic [2:0] OP_RESCHED = 3'd2;
  localparam logic [2:0] OP_SKIP = 3'd3;
  localparam logic [2:0] OP_POLL = 3'd4;
  localparam logic [2:0] OP_REMAIN = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_EXIST = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_LOAD, S_DECIDE, S_DIV, S_ADV1, S_ADV2, S_SKIP, S_WRITE, S_OUT
  } state_t;
endpackage

// ===== rtl/core/ptt_div.sv =====
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
module ptt_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ptt_pkg::TIME_W-1:0]    dividend,
  input  logic [ptt_pkg::TIME_W-1:0]    divisor,
  output logic [ptt_pkg::TIME_W-1:0]    quo,
  output logic [ptt_pkg::TIME_W-1:0]    rem,
  output logic                          done
);
  localparam int CW = $clog2(ptt_pkg::TIME_W + 1);

  logic [ptt_pkg::TIME_W-1:0] dvs;
  logic [CW-1:0] cnt;
  logic busy;
  logic [ptt_pkg::TIME_W:0] trial;
  logic [ptt_pkg::TIME_W:0] diff;

  assign trial = {rem, quo[ptt_pkg::TIME_W-1]};
  assign diff = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(ptt_pkg::TIME_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[ptt_pkg::TIME_W]) begin
        rem <= diff[ptt_pkg::TIME_W-1:0];
        quo <= {quo[ptt_pkg::TIME_W-2:0], 1'b1};
      end else begin
        rem <= trial[ptt_pkg::TIME_W-1:0];
        quo <= {quo[ptt_pkg::TIME_W-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== rtl/core/periodic_timer_table.sv =====
// Periodic timer table top level: slot store, sequencer, min scan and reload arithmetic.
// One request at a time; in_ready only in idle, so a new request is not taken until the reply is accepted.
// Path from accept to out_valid: load, decide, optional skip step and slot write, then a full slot scan.
// Poll first scans for the earliest slot; a one-shot that fires adds a slot write.
// A periodic advance adds the divider and the ADV1 and ADV2 steps before the write.
// Reset (synchronous): all slots idle, last deadline all ones; slot data undefined.
module periodic_timer_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [3:0]  timer_id,
  input  logic [63:0] expiry_time,
  input  logic [63:0] period,
  input  logic [63:0] now_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        expired_valid,
  output logic [3:0]  expired_slot,
  output logic [31:0] fire_count,
  output logic [63:0] time_left,
  output logic [63:0] earliest_deadline,
  output logic        deadline_changed
);
  localparam int TW = ptt_pkg::TIME_W;
  localparam int CW = ptt_pkg::CNT_W;
  localparam int SW = ptt_pkg::SLOT_W;

  ptt_pkg::state_t state, state_next;

  logic [TW-1:0] exp_mem [ptt_pkg::NUM_SLOTS];
  logic [TW-1:0] per_mem [ptt_pkg::NUM_SLOTS];
  logic [CW-1:0] cnt_mem [ptt_pkg::NUM_SLOTS];
  logic [ptt_pkg::NUM_SLOTS-1:0] running;
  logic [TW-1:0] last_deadline;

  logic [2:0] op_r;
  logic id_ok;
  logic [TW-1:0] exp_in, per_in, now_r;

  logic [SW-1:0] idx;
  logic poll_scan;
  logic best_found;
  logic [TW-1:0] best_exp;
  logic [SW-1:0] best_idx;
  logic [SW-1:0] poll_slot;

  logic [TW-1:0] w_exp, w_per;
  logic [CW-1:0] w_cnt;
  logic w_run;
  logic is_skip;
  logic [TW-1:0] step, n_r;

  logic [1:0] st_r;
  logic xv_r;
  logic rep_cnt;
  logic [TW-1:0] left_r;

  logic div_start, div_done;
  logic [TW-1:0] quo, rem;

  logic scan_last;
  logic due;
  logic [TW-1:0] diff;
  logic [TW:0] step_sum, exp_sum, skip_sum;
  logic [TW-1:0] n_val;

  assign scan_last = (idx == SW'(ptt_pkg::NUM_SLOTS - 1));
  assign due = (now_r >= w_exp);
  assign diff = now_r - w_exp;
  assign step_sum = {1'b0, diff - rem} + {1'b0, w_per};
  assign n_val = (&quo) ? quo : quo + 1'b1;
  assign exp_sum = {1'b0, w_exp} + {1'b0, step};
  assign skip_sum = {1'b0, w_exp} + {1'b0, w_per};

  ptt_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(diff), .divisor(w_per),
    .quo(quo), .rem(rem), .done(div_done)
  );

  assign in_ready = (state == ptt_pkg::S_IDLE);
  assign out_valid = (state == ptt_pkg::S_OUT);

  always_ff @(posedge clk) begin
    if (rst) state <= ptt_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    unique case (state)
      ptt_pkg::S_IDLE: begin
        if (in_valid) state_next = (op == ptt_pkg::OP_POLL) ? ptt_pkg::S_SCAN : ptt_pkg::S_LOAD;
      end
      ptt_pkg::S_SCAN: begin
        if (scan_last) state_next = poll_scan ? ptt_pkg::S_LOAD : ptt_pkg::S_OUT;
      end
      ptt_pkg::S_LOAD: state_next = ptt_pkg::S_DECIDE;
      ptt_pkg::S_DECIDE: begin
        state_next = ptt_pkg::S_SCAN;
        if (op_r > ptt_pkg::OP_REMAIN) begin
          state_next = ptt_pkg::S_SCAN;
        end else if (op_r == ptt_pkg::OP_POLL) begin
          if (best_found && due) begin
            if (w_per == '0) state_next = ptt_pkg::S_WRITE;
            else begin
              state_next = ptt_pkg::S_DIV;
              div_start = 1'b1;
            end
          end
        end else if (!id_ok) begin
          state_next = ptt_pkg::S_SCAN;
        end else if (op_r == ptt_pkg::OP_START) begin
          state_next = ptt_pkg::S_WRITE;
        end else if (!w_run) begin
          state_next = ptt_pkg::S_SCAN;
        end else if (op_r == ptt_pkg::OP_STOP) begin
          state_next = ptt_pkg::S_WRITE;
        end else if (op_r == ptt_pkg::OP_RESCHED) begin
          if (((per_in == '0) == (w_per == '0)) && !(per_in == '0 && due))
            state_next = ptt_pkg::S_WRITE;
        end else if (op_r == ptt_pkg::OP_SKIP) begin
          if (w_per != '0) begin
            if (due) begin
              state_next = ptt_pkg::S_DIV;
              div_start = 1'b1;
            end else begin
              state_next = ptt_pkg::S_SKIP;
            end
          end
        end
      end
      ptt_pkg::S_DIV: if (div_done) state_next = ptt_pkg::S_ADV1;
      ptt_pkg::S_ADV1: state_next = ptt_pkg::S_ADV2;
      ptt_pkg::S_ADV2: state_next = is_skip ? ptt_pkg::S_SKIP : ptt_pkg::S_WRITE;
      ptt_pkg::S_SKIP: state_next = ptt_pkg::S_WRITE;
      ptt_pkg::S_WRITE: state_next = ptt_pkg::S_SCAN;
      ptt_pkg::S_OUT: if (out_ready) state_next = ptt_pkg::S_IDLE;
      default: state_next = ptt_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= '0;
      last_deadline <= '1;
      idx <= '0;
      poll_scan <= 1'b0;
      best_found <= 1'b0;
    end else begin
      unique case (state)
        ptt_pkg::S_IDLE: begin
          if (in_valid) begin
            idx <= (op == ptt_pkg::OP_POLL) ? '0 : SW'(timer_id);
            poll_scan <= (op == ptt_pkg::OP_POLL);
            best_found <= 1'b0;
          end
        end
        ptt_pkg::S_SCAN: begin
          if (running[idx] && (!best_found || exp_mem[idx] < best_exp))
            best_found <= 1'b1;
          if (scan_last) begin
            idx <= best_idx;
            if (running[idx] && (!best_found || exp_mem[idx] < best_exp))
              idx <= idx;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ptt_pkg::S_WRITE: begin
          running[idx] <= w_run;
          idx <= '0;
          best_found <= 1'b0;
          poll_scan <= 1'b0;
        end
        ptt_pkg::S_DECIDE: begin
          if (state_next == ptt_pkg::S_SCAN) begin
            idx <= '0;
            best_found <= 1'b0;
            poll_scan <= 1'b0;
          end
        end
        ptt_pkg::S_OUT: begin
          if (out_ready) last_deadline <= earliest_deadline;
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ptt_pkg::S_IDLE: begin
        if (in_valid) begin
          op_r <= op;
          id_ok <= ({1'b0, timer_id} < 5'(ptt_pkg::NUM_SLOTS)) || (ptt_pkg::NUM_SLOTS > 15);
          exp_in <= expiry_time;
          per_in <= period;
          now_r <= now_time;
          best_exp <= '1;
          best_idx <= '0;
          st_r <= ptt_pkg::ST_OK;
          xv_r <= 1'b0;
          rep_cnt <= 1'b0;
          left_r <= '0;
          is_skip <= 1'b0;
        end
      end
      ptt_pkg::S_SCAN: begin
        if (running[idx] && (!best_found || exp_mem[idx] < best_exp)) begin
          best_exp <= exp_mem[idx];
          best_idx <= idx;
        end
      end
      ptt_pkg::S_LOAD: begin
        w_exp <= exp_mem[idx];
        w_per <= per_mem[idx];
        w_cnt <= cnt_mem[idx];
        w_run <= running[idx];
      end
      ptt_pkg::S_DECIDE: begin
        best_exp <= '1;
        best_idx <= '0;
        if (op_r > ptt_pkg::OP_REMAIN) begin
          st_r <= ptt_pkg::ST_INVALID;
        end else if (op_r == ptt_pkg::OP_POLL) begin
          if (best_found && due) begin
            xv_r <= 1'b1;
            rep_cnt <= 1'b1;
            if (w_per == '0) begin
              w_run <= 1'b0;
              if (w_cnt != '1) w_cnt <= w_cnt + 1'b1;
            end
          end
        end else if (!id_ok) begin
          st_r <= ptt_pkg::ST_INVALID;
        end else if (op_r == ptt_pkg::OP_START) begin
          w_exp <= exp_in;
          w_per <= per_in;
          w_cnt <= '0;
          w_run <= 1'b1;
        end else if (!w_run) begin
          st_r <= ptt_pkg::ST_NOT_EXIST;
        end else if (op_r == ptt_pkg::OP_STOP) begin
          w_run <= 1'b0;
          rep_cnt <= 1'b1;
        end else if (op_r == ptt_pkg::OP_RESCHED) begin
          if ((per_in == '0) != (w_per == '0)) st_r <= ptt_pkg::ST_INVALID;
          else if (per_in == '0 && due) st_r <= ptt_pkg::ST_NOT_EXIST;
          else begin
            w_exp <= exp_in;
            w_per <= per_in;
            rep_cnt <= 1'b1;
          end
        end else if (op_r == ptt_pkg::OP_SKIP) begin
          if (w_per == '0) st_r <= ptt_pkg::ST_NOT_EXIST;
          else begin
            rep_cnt <= 1'b1;
            is_skip <= 1'b1;
          end
        end else begin
          if (w_exp >= now_r) left_r <= w_exp - now_r;
          rep_cnt <= 1'b1;
        end
      end
      ptt_pkg::S_ADV1: begin
        step <= step_sum[TW] ? '1 : step_sum[TW-1:0];
        n_r <= n_val;
      end
      ptt_pkg::S_ADV2: begin
        w_exp <= exp_sum[TW] ? '1 : exp_sum[TW-1:0];
        if (n_r >= {{(TW-CW){1'b0}}, ~w_cnt}) w_cnt <= '1;
        else w_cnt <= w_cnt + n_r[CW-1:0];
      end
      ptt_pkg::S_SKIP: begin
        w_exp <= skip_sum[TW] ? '1 : skip_sum[TW-1:0];
      end
      ptt_pkg::S_WRITE: begin
        exp_mem[idx] <= w_exp;
        per_mem[idx] <= w_per;
        cnt_mem[idx] <= w_cnt;
        best_exp <= '1;
        best_idx <= '0;
      end
      default: ;
    endcase
  end

  // slot reported by poll is the one loaded into the working registers
  always_ff @(posedge clk) begin
    if (state == ptt_pkg::S_LOAD) poll_slot <= idx;
  end

  assign status = st_r;
  assign expired_valid = xv_r;
  assign expired_slot = xv_r ? 4'(poll_slot) : 4'd0;
  assign fire_count = rep_cnt ? w_cnt : '0;
  assign time_left = left_r;
  assign earliest_deadline = best_found ? best_exp : '1;
  assign deadline_changed = (earliest_deadline != last_deadline);
endmodule

// ===== tb/periodic_timer_table_test.sv =====
// Testbench for the periodic timer table: directed and random requests checked by a predictor.
module periodic_timer_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_BAD6 = 3'd6;
  localparam logic [2:0] OP_BAD7 = 3'd7;
  localparam logic [63:0] ALL1 = '1;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [1:0]  status;
    logic        expired_valid;
    logic [3:0]  expired_slot;
    logic [31:0] fire_count;
    logic [63:0] time_left;
    logic [63:0] earliest_deadline;
    logic        deadline_changed;
  } reply_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [2:0] op = '0;
  logic [3:0] timer_id = '0;
  logic [63:0] expiry_time = '0, period = '0, now_time = '0;
  logic [1:0] status;
  logic expired_valid, deadline_changed;
  logic [3:0] expired_slot;
  logic [31:0] fire_count;
  logic [63:0] time_left, earliest_deadline;

  periodic_timer_table dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // model state
  logic [63:0] m_expiry [ptt_pkg::NUM_SLOTS];
  logic [63:0] m_period [ptt_pkg::NUM_SLOTS];
  logic [31:0] m_count [ptt_pkg::NUM_SLOTS];
  logic        m_run [ptt_pkg::NUM_SLOTS];
  logic [63:0] m_last;
  reply_t pending_replies[$];
  int errors = 0, sent = 0, got = 0, polls_hit = 0, idle_cnt = 0;
  int out_wait = 0, out_draw = 0;
  logic [63:0] clock_ns = 0;

  function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? ALL1 : s[63:0];
  endfunction

  function automatic logic [63:0] smul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return (p[127:64] != 0) ? ALL1 : p[63:0];
  endfunction

  function automatic void bump(int s, logic [63:0] n);
    logic [63:0] room;
    room = 64'(32'hFFFFFFFF - m_count[s]);
    if (n >= room) m_count[s] = '1;
    else m_count[s] = m_count[s] + n[31:0];
  endfunction

  function automatic void catch_up(int s, logic [63:0] now);
    logic [63:0] n;
    n = 64'd1;
    if (m_period[s] != 0) n = sadd((now - m_expiry[s]) / m_period[s], 64'd1);
    m_expiry[s] = sadd(m_expiry[s], smul(n, m_period[s]));
    bump(s, n);
  endfunction

  function automatic int first_due_slot();
    int best;
    best = ptt_pkg::NUM_SLOTS;
    for (int i = 0; i < ptt_pkg::NUM_SLOTS; i++)
      if (m_run[i] && (best == ptt_pkg::NUM_SLOTS || m_expiry[i] < m_expiry[best])) best = i;
    return best;
  endfunction

  function automatic reply_t timer_table_step(logic [2:0] o, logic [3:0] id,
                                              logic [63:0] ex, logic [63:0] pe,
                                              logic [63:0] now);
    reply_t r;
    int e, s;
    r = '0;
    s = id;
    if (o > ptt_pkg::OP_REMAIN) r.status = ptt_pkg::ST_INVALID;
    else if (o == ptt_pkg::OP_POLL) begin
      e = first_due_slot();
      if (e < ptt_pkg::NUM_SLOTS && now >= m_expiry[e]) begin
        if (m_period[e] == 0) begin
          m_run[e] = 0;
          bump(e, 64'd1);
        end else catch_up(e, now);
        r.expired_valid = 1;
        r.expired_slot = e[3:0];
        r.fire_count = m_count[e];
      end
    end else if (s >= ptt_pkg::NUM_SLOTS) r.status = ptt_pkg::ST_INVALID;
    else if (o == ptt_pkg::OP_START) begin
      m_expiry[s] = ex; m_period[s] = pe; m_count[s] = 0; m_run[s] = 1;
    end else if (!m_run[s]) r.status = ptt_pkg::ST_NOT_EXIST;
    else if (o == ptt_pkg::OP_STOP) begin
      m_run[s] = 0;
      r.fire_count = m_count[s];
    end else if (o == ptt_pkg::OP_RESCHED) begin
      if ((pe == 0) != (m_period[s] == 0)) r.status = ptt_pkg::ST_INVALID;
      else if (pe == 0 && m_expiry[s] <= now) r.status = ptt_pkg::ST_NOT_EXIST;
      else begin
        m_expiry[s] = ex; m_period[s] = pe;
        r.fire_count = m_count[s];
      end
    end else if (o == ptt_pkg::OP_SKIP) begin
      if (m_period[s] == 0) r.status = ptt_pkg::ST_NOT_EXIST;
      else begin
        if (now >= m_expiry[s]) catch_up(s, now);
        m_expiry[s] = sadd(m_expiry[s], m_period[s]);
        r.fire_count = m_count[s];
      end
    end else begin
      if (m_expiry[s] >= now) r.time_left = m_expiry[s] - now;
      r.fire_count = m_count[s];
    end
    e = first_due_slot();
    r.earliest_deadline = (e < ptt_pkg::NUM_SLOTS) ? m_expiry[e] : ALL1;
    r.deadline_changed = r.earliest_deadline != m_last;
    m_last = r.earliest_deadline;
    return r;
  endfunction

  // valid drops only when a gap follows, so a beat never gets two drives in one step
  task automatic send_request(logic [2:0] o, logic [3:0] id, logic [63:0] ex,
                              logic [63:0] pe, logic [63:0] now);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; op <= o; timer_id <= id;
    expiry_time <= ex; period <= pe; now_time <= now;
    do @(posedge clk); while (!in_ready);
    pending_replies.push_back(timer_table_step(o, id, ex, pe, now));
    sent++;
  endtask

  // receiver stall and checker
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        reply_t act, exp_r;
        act = {status, expired_valid, expired_slot, fire_count, time_left,
               earliest_deadline, deadline_changed};
        got++;
        if (pending_replies.size() == 0) begin
          $display("%0t: unexpected reply %h", $time, act);
          errors++;
        end else begin
          exp_r = pending_replies.pop_front();
          if (exp_r.expired_valid) polls_hit++;
          if (act.status != exp_r.status) begin
            $display("%0t: status exp %0d act %0d", $time, exp_r.status, act.status); errors++;
          end
          if (act.expired_valid != exp_r.expired_valid) begin
            $display("%0t: expired_valid exp %0d act %0d", $time, exp_r.expired_valid,
                     act.expired_valid); errors++;
          end
          if (act.expired_slot != exp_r.expired_slot) begin
            $display("%0t: expired_slot exp %0d act %0d", $time, exp_r.expired_slot,
                     act.expired_slot); errors++;
          end
          if (act.fire_count != exp_r.fire_count) begin
            $display("%0t: fire_count exp %0d act %0d", $time, exp_r.fire_count,
                     act.fire_count); errors++;
          end
          if (act.time_left != exp_r.time_left) begin
            $display("%0t: time_left exp %0d act %0d", $time, exp_r.time_left,
                     act.time_left); errors++;
          end
          if (act.earliest_deadline != exp_r.earliest_deadline) begin
            $display("%0t: earliest_deadline exp %h act %h", $time,
                     exp_r.earliest_deadline, act.earliest_deadline); errors++;
          end
          if (act.deadline_changed != exp_r.deadline_changed) begin
            $display("%0t: deadline_changed exp %0d act %0d", $time,
                     exp_r.deadline_changed, act.deadline_changed); errors++;
          end
        end
        out_draw = $urandom_range(0, 16);
        out_wait <= out_draw;
        out_ready <= (out_draw == 0);
      end else if (out_valid && !out_ready) begin
        if (out_wait == 0) out_ready <= 1;
        else out_wait <= out_wait - 1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > STALL_LIMIT) begin
      $display("periodic_timer_table_test: FAIL");
      $finish;
    end
  end

  task automatic drain_replies();
    in_valid <= 0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    send_request(ptt_pkg::OP_POLL, 0, 0, 0, 0);
    send_request(ptt_pkg::OP_STOP, 3, 0, 0, 0);
    send_request(ptt_pkg::OP_START, 0, 100, 0, 10);
    send_request(ptt_pkg::OP_START, 1, 100, 30, 10);
    send_request(ptt_pkg::OP_START, 15, ALL1, ALL1, 0);
    send_request(ptt_pkg::OP_REMAIN, 0, 0, 0, 40);
    send_request(ptt_pkg::OP_REMAIN, 0, 0, 0, 400);
    send_request(ptt_pkg::OP_RESCHED, 0, 200, 5, 10);
    send_request(ptt_pkg::OP_RESCHED, 1, 200, 0, 10);
    send_request(ptt_pkg::OP_RESCHED, 0, 150, 0, 10);
    send_request(ptt_pkg::OP_POLL, 0, 0, 0, 1000);
    send_request(ptt_pkg::OP_RESCHED, 0, 300, 0, 5000);
    send_request(ptt_pkg::OP_SKIP, 0, 0, 0, 0);
    send_request(ptt_pkg::OP_SKIP, 1, 0, 0, 50);
    send_request(ptt_pkg::OP_POLL, 9, 0, 0, 10000);
    send_request(ptt_pkg::OP_POLL, 0, 0, 0, ALL1);
    send_request(ptt_pkg::OP_START, 2, 0, 1, 0);
    send_request(ptt_pkg::OP_SKIP, 2, 0, 0, ALL1);
    send_request(OP_BAD6, 0, 0, 0, 0);
    send_request(OP_BAD7, 15, ALL1, ALL1, ALL1);
    send_request(ptt_pkg::OP_START, 2, 500, 0, 0);
    send_request(ptt_pkg::OP_STOP, 2, 0, 0, 0);
    send_request(ptt_pkg::OP_STOP, 15, 0, 0, 0);
    send_request(ptt_pkg::OP_STOP, 1, 0, 0, 0);
  endtask

  task automatic test_random(int n);
    logic [2:0] o;
    logic [63:0] ex, pe;
    for (int i = 0; i < n; i++) begin
      clock_ns = clock_ns + $urandom_range(0, 200);
      o = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 5));
      case ($urandom_range(0, 9))
        0: begin ex = rand64(); pe = rand64(); end
        1: begin ex = clock_ns + $urandom_range(0, 500); pe = 0; end
        default: begin
          ex = clock_ns + $urandom_range(0, 400);
          pe = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 100);
        end
      endcase
      if (i == n / 2) begin
        drain_replies();
        clock_ns = clock_ns + 64'd1_000_000;
      end
      send_request(o, 4'($urandom_range(0, 15)), ex, pe,
                   ($urandom_range(0, 30) == 0) ? rand64() : clock_ns);
    end
  endtask

  initial begin
    for (int i = 0; i < ptt_pkg::NUM_SLOTS; i++) begin
      m_run[i] = 0; m_expiry[i] = 0; m_period[i] = 0; m_count[i] = 0;
    end
    m_last = ALL1;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random(480);
    drain_replies();
    repeat (200) @(posedge clk);
    $display("Sent %0d requests, %0d replies, %0d polls found a due slot.",
             sent, got, polls_hit);
    if (errors == 0 && pending_replies.size() == 0)
      $display("periodic_timer_table_test: PASS");
    else
      $display("periodic_timer_table_test: FAIL");
    $finish;
  end
endmodule
